@@ hw/rtl/lgsp_pkg.sv @@
// Package: shared types and constants for the ladder shortest-path engine.
package lgsp_pkg;

  localparam int unsigned MaxSpans = 1024;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ColW     = 11;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned DistW    = 48;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [KindW-1:0] {
    KIND_TOP    = 2'd0,
    KIND_RUNG   = 2'd1,
    KIND_BOTTOM = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_MARK,
    ST_RLX_RD,
    ST_RLX_WR,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_e;

  typedef struct packed {
    logic             vis;
    logic [DistW-1:0] plen;
  } node_t;

endpackage

@@ hw/rtl/lgsp_if.sv @@
// Interfaces: input word channel and result word channel.
interface lgsp_in_if;
  logic                              valid;
  logic                              ready;
  logic [lgsp_pkg::KindW-1:0]        kind;
  logic [lgsp_pkg::ColW-1:0]         column;
  logic [lgsp_pkg::WeightW-1:0]      weight;
  logic                              source_row;
  logic [lgsp_pkg::ColW-1:0]         source_col;
  logic                              target_row;
  logic [lgsp_pkg::ColW-1:0]         target_col;

  modport source (output valid, kind, column, weight, source_row, source_col,
                  target_row, target_col, input ready);
  modport sink   (input valid, kind, column, weight, source_row, source_col,
                  target_row, target_col, output ready);
endinterface

interface lgsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgsp_pkg::DistW-1:0]  distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

@@ hw/rtl/ladder_graph_shortest_path_top.sv @@
// Ladder shortest-path engine: weight stores, node store and Dijkstra sequencer.
// Load words (top span, rung, bottom span) are written and the block is
// ready again the next cycle. A query, with t = effective span count, first clears
// the 2(t+1) nodes of the node store, then per settled node scans them for the
// nearest unvisited node, marks it and relaxes its neighbours, then runs one
// last scan that finds nothing and reads out the result. The query time is
// set by the single read port of the node store, which the minimum search
// walks one node per cycle.
// A result waiting at the output does not block further load words.
module ladder_graph_shortest_path_top #(
  parameter int unsigned MAX_SPANS = lgsp_pkg::MaxSpans
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lgsp_pkg::ColW-1:0]  cfg_data_i,
  lgsp_in_if.sink                    in_i,
  lgsp_out_if.source                 out_o
);

  localparam int unsigned CW = $clog2(MAX_SPANS + 1);
  localparam int unsigned SW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int unsigned NW = CW + 1;
  localparam int unsigned NodeDepth = 2 ** NW;

  // stores
  logic [lgsp_pkg::WeightW-1:0] top_mem  [MAX_SPANS];
  logic [lgsp_pkg::WeightW-1:0] rung_mem [MAX_SPANS+1];
  logic [lgsp_pkg::WeightW-1:0] bot_mem  [MAX_SPANS];
  lgsp_pkg::node_t              node_mem [NodeDepth];

  logic [lgsp_pkg::ColW-1:0] span_q;
  lgsp_pkg::state_e state_q, state_d;
  logic [CW-1:0] t_q, t_d;
  logic [NW-1:0] src_q, src_d, dst_q, dst_d;
  logic [NW-1:0] scan_q, scan_d;
  logic          last_q, last_d;
  logic          pv_q, pv_d;
  logic [NW-1:0] pn_q, pn_d;
  logic [NW-1:0] best_q, best_d;
  logic [lgsp_pkg::DistW-1:0] bdist_q, bdist_d;
  logic          found_q, found_d;
  logic [1:0]    nbr_q, nbr_d;
  logic          ovld_q, ovld_d;
  logic [lgsp_pkg::DistW-1:0] odist_q, odist_d;

  logic                         nm_we;
  logic [NW-1:0]                nm_wa, nm_ra;
  lgsp_pkg::node_t              nm_wd, nm_rd_q;
  logic [CW-1:0]                w_ra;
  logic [SW-1:0]                sw_ra;
  logic [lgsp_pkg::WeightW-1:0] top_rd_q, rung_rd_q, bot_rd_q;

  logic          in_acc;
  logic [CW-1:0] t_eff, scol, tcol;
  logic [NW-1:0] scan_nx;
  logic          scan_end;
  logic          nv;
  logic [NW-1:0] nnode;
  logic [CW-1:0] bc;
  logic          br;
  logic [lgsp_pkg::WeightW-1:0] w_sel;
  logic [lgsp_pkg::DistW-1:0]   cand;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == lgsp_pkg::ST_IDLE);
  assign out_o.valid = ovld_q;
  assign out_o.distance = odist_q;

  // effective span count and saturated query columns
  always_comb begin
    if (span_q == '0) t_eff = CW'(1);
    else if (32'(span_q) > 32'(MAX_SPANS)) t_eff = CW'(MAX_SPANS);
    else t_eff = CW'(span_q);
    scol = (32'(in_i.source_col) > 32'(t_eff)) ? t_eff : CW'(in_i.source_col);
    tcol = (32'(in_i.target_col) > 32'(t_eff)) ? t_eff : CW'(in_i.target_col);
  end

  // walk order: top row columns 0..t, then bottom row 0..t
  assign scan_end = (scan_q[CW-1:0] == t_q) && scan_q[CW];
  always_comb begin
    if (scan_q[CW-1:0] == t_q) scan_nx = {1'b1, {CW{1'b0}}};
    else scan_nx = scan_q + NW'(1);
  end

  // neighbor of the settled node selected by nbr_q
  assign br = best_q[CW];
  assign bc = best_q[CW-1:0];
  always_comb begin
    nv = 1'b0;
    nnode = best_q;
    w_ra = bc;
    case (nbr_q)
      2'd0: begin
        nv = (bc < t_q);
        nnode = {br, bc + CW'(1)};
      end
      2'd1: begin
        nv = (bc != '0);
        nnode = {br, bc - CW'(1)};
        w_ra = bc - CW'(1);
      end
      2'd2: begin
        nv = 1'b1;
        nnode = {~br, bc};
      end
      default: nv = 1'b0;
    endcase
  end

  // span stores only matter below MAX_SPANS, where the truncation is exact
  assign sw_ra = SW'(w_ra);

  assign w_sel = (nbr_q == 2'd2) ? rung_rd_q : (br ? bot_rd_q : top_rd_q);
  assign cand  = bdist_q + lgsp_pkg::DistW'(w_sel);

  always_comb begin
    state_d = state_q;
    t_d = t_q;
    src_d = src_q;
    dst_d = dst_q;
    scan_d = scan_q;
    last_d = last_q;
    pv_d = 1'b0;
    pn_d = pn_q;
    best_d = best_q;
    bdist_d = bdist_q;
    found_d = found_q;
    nbr_d = nbr_q;
    ovld_d = ovld_q && !out_o.ready;
    odist_d = odist_q;
    nm_we = 1'b0;
    nm_wa = scan_q;
    nm_wd = '{vis: 1'b0, plen: lgsp_pkg::DistMax};
    nm_ra = scan_q;
    unique case (state_q)
      lgsp_pkg::ST_IDLE: begin
        if (in_acc && (in_i.kind == lgsp_pkg::KIND_QUERY)) begin
          t_d = t_eff;
          src_d = {in_i.source_row, scol};
          dst_d = {in_i.target_row, tcol};
          scan_d = '0;
          state_d = lgsp_pkg::ST_CLEAR;
        end
      end
      lgsp_pkg::ST_CLEAR: begin
        nm_we = 1'b1;
        nm_wa = scan_q;
        nm_wd.plen = (scan_q == src_q) ? '0 : lgsp_pkg::DistMax;
        scan_d = scan_nx;
        if (scan_end) begin
          scan_d = '0;
          last_d = 1'b0;
          bdist_d = lgsp_pkg::DistMax;
          found_d = 1'b0;
          state_d = lgsp_pkg::ST_SCAN;
        end
      end
      lgsp_pkg::ST_SCAN: begin
        // read issued this cycle, compared the next
        nm_ra = scan_q;
        if (!last_q) begin
          pv_d = 1'b1;
          pn_d = scan_q;
          scan_d = scan_nx;
          last_d = scan_end;
        end
        if (pv_q && !nm_rd_q.vis && (nm_rd_q.plen < bdist_q)) begin
          bdist_d = nm_rd_q.plen;
          best_d = pn_q;
          found_d = 1'b1;
        end
        if (last_q && !pv_q) begin
          state_d = found_q ? lgsp_pkg::ST_MARK : lgsp_pkg::ST_FIN_RD;
        end
      end
      lgsp_pkg::ST_MARK: begin
        nm_we = 1'b1;
        nm_wa = best_q;
        nm_wd = '{vis: 1'b1, plen: bdist_q};
        nbr_d = 2'd0;
        state_d = lgsp_pkg::ST_RLX_RD;
      end
      lgsp_pkg::ST_RLX_RD: begin
        nm_ra = nnode;
        if (nv) begin
          state_d = lgsp_pkg::ST_RLX_WR;
        end else if (nbr_q == 2'd2) begin
          scan_d = '0;
          last_d = 1'b0;
          bdist_d = lgsp_pkg::DistMax;
          found_d = 1'b0;
          state_d = lgsp_pkg::ST_SCAN;
        end else begin
          nbr_d = nbr_q + 2'd1;
        end
      end
      lgsp_pkg::ST_RLX_WR: begin
        nm_wa = nnode;
        nm_wd = '{vis: 1'b0, plen: cand};
        nm_we = !nm_rd_q.vis && (cand < nm_rd_q.plen);
        if (nbr_q == 2'd2) begin
          scan_d = '0;
          last_d = 1'b0;
          bdist_d = lgsp_pkg::DistMax;
          found_d = 1'b0;
          state_d = lgsp_pkg::ST_SCAN;
        end else begin
          nbr_d = nbr_q + 2'd1;
          state_d = lgsp_pkg::ST_RLX_RD;
        end
      end
      lgsp_pkg::ST_FIN_RD: begin
        nm_ra = dst_q;
        state_d = lgsp_pkg::ST_FIN_OUT;
      end
      lgsp_pkg::ST_FIN_OUT: begin
        nm_ra = dst_q;
        if (!ovld_q || out_o.ready) begin
          ovld_d = 1'b1;
          odist_d = nm_rd_q.plen;
          state_d = lgsp_pkg::ST_IDLE;
        end
      end
      default: state_d = lgsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgsp_pkg::ST_IDLE;
      span_q  <= lgsp_pkg::ColW'(1);
      ovld_q  <= 1'b0;
      last_q  <= 1'b0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      nbr_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) span_q <= cfg_data_i;
      ovld_q  <= ovld_d;
      last_q  <= last_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      nbr_q   <= nbr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    src_q <= src_d;
    dst_q <= dst_d;
    scan_q <= scan_d;
    pn_q <= pn_d;
    best_q <= best_d;
    bdist_q <= bdist_d;
    odist_q <= odist_d;
  end

  // weight stores
  always_ff @(posedge clk_i) begin
    if (in_acc && (32'(in_i.column) < 32'(MAX_SPANS))) begin
      if (in_i.kind == lgsp_pkg::KIND_TOP) top_mem[SW'(in_i.column)] <= in_i.weight;
      if (in_i.kind == lgsp_pkg::KIND_BOTTOM) bot_mem[SW'(in_i.column)] <= in_i.weight;
    end
    if (in_acc && (in_i.kind == lgsp_pkg::KIND_RUNG)
        && (32'(in_i.column) <= 32'(MAX_SPANS))) begin
      rung_mem[CW'(in_i.column)] <= in_i.weight;
    end
    top_rd_q  <= top_mem[sw_ra];
    bot_rd_q  <= bot_mem[sw_ra];
    rung_rd_q <= rung_mem[w_ra];
  end

  // node store: distance and visited mark
  always_ff @(posedge clk_i) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    nm_rd_q <= node_mem[nm_ra];
  end

endmodule

@@ hw/rtl/lgsp_checker.sv @@
// Port checker for the ladder shortest-path engine, bound to the top level.
module lgsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [lgsp_pkg::KindW-1:0] in_kind_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lgsp_pkg::DistW-1:0] out_distance_i
);

  // a query holds off the next word
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == lgsp_pkg::KIND_QUERY)) |=> !in_ready_i)
    else $error("ready after query word");

  // a load word leaves the block ready for the next word
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i != lgsp_pkg::KIND_QUERY)) |=> in_ready_i)
    else $error("not ready after load word");

  // result cannot appear while idle with nothing in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_i)) |-> !in_ready_i || $past(!in_ready_i))
    else $error("result without a query");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_distance_i)))
    else $error("stalled result changed");

endmodule

bind ladder_graph_shortest_path_top lgsp_checker u_lgsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_distance_i (out_o.distance)
);

@@ tb/tb.sv @@
// Testbench for the ladder shortest-path engine: random weight loads and distance queries.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxCol    = 63;      // highest column preloaded; queries stay within
  localparam int unsigned IdleLimit = 400000;

  typedef struct {
    lgsp_pkg::kind_e                  kind;
    logic [lgsp_pkg::ColW-1:0]        column;
    logic [lgsp_pkg::WeightW-1:0]     weight;
    logic                             source_row;
    logic [lgsp_pkg::ColW-1:0]        source_col;
    logic                             target_row;
    logic [lgsp_pkg::ColW-1:0]        target_col;
  } word_t;

  // Holds its own copy of the weight stores and span count and the queue of
  // distances still owed by the block.
  class dist_board;
    logic [lgsp_pkg::ColW-1:0]    span_reg = 1;
    logic [lgsp_pkg::WeightW-1:0] top_w    [lgsp_pkg::MaxSpans];
    logic [lgsp_pkg::WeightW-1:0] rung_w   [lgsp_pkg::MaxSpans+1];
    logic [lgsp_pkg::WeightW-1:0] bot_w    [lgsp_pkg::MaxSpans];
    logic [lgsp_pkg::DistW-1:0]   node_len [2][lgsp_pkg::MaxSpans+1];
    bit                           seen     [2][lgsp_pkg::MaxSpans+1];
    logic [lgsp_pkg::DistW-1:0]   owed     [$];
    int                           errors, loads, queries, results;

    function void relax(int unsigned r, int unsigned c, logic [lgsp_pkg::DistW-1:0] from,
                        logic [lgsp_pkg::WeightW-1:0] w);
      logic [lgsp_pkg::DistW-1:0] nd;
      nd = from + lgsp_pkg::DistW'(w);
      if (!seen[r][c] && nd < node_len[r][c]) node_len[r][c] = nd;
    endfunction

    function logic [lgsp_pkg::DistW-1:0] shortest(word_t w);
      int unsigned t, sc, tc, r, c, br, bc, it;
      logic [lgsp_pkg::DistW-1:0] bd;
      bit found;
      t = (span_reg == 0) ? 1 : (span_reg > lgsp_pkg::MaxSpans) ? lgsp_pkg::MaxSpans : span_reg;
      sc = (w.source_col > t) ? t : w.source_col;
      tc = (w.target_col > t) ? t : w.target_col;
      for (r = 0; r < 2; r++) begin
        for (c = 0; c <= t; c++) begin
          node_len[r][c] = lgsp_pkg::DistMax;
          seen[r][c] = 1'b0;
        end
      end
      node_len[w.source_row][sc] = '0;
      for (it = 0; it < 2 * (t + 1); it++) begin
        found = 1'b0;
        bd = lgsp_pkg::DistMax;
        br = 0;
        bc = 0;
        for (r = 0; r < 2; r++) begin
          for (c = 0; c <= t; c++) begin
            if (!seen[r][c] && node_len[r][c] < bd) begin
              bd = node_len[r][c];
              br = r;
              bc = c;
              found = 1'b1;
            end
          end
        end
        if (!found) break;
        seen[br][bc] = 1'b1;
        if (bc < t) relax(br, bc + 1, bd, br ? bot_w[bc] : top_w[bc]);
        if (bc > 0) relax(br, bc - 1, bd, br ? bot_w[bc-1] : top_w[bc-1]);
        relax(1 - br, bc, bd, rung_w[bc]);
      end
      return node_len[w.target_row][tc];
    endfunction

    function void note_word(word_t w);
      case (w.kind)
        lgsp_pkg::KIND_TOP: begin
          if (w.column < lgsp_pkg::MaxSpans) top_w[w.column] = w.weight;
          loads++;
        end
        lgsp_pkg::KIND_RUNG: begin
          if (w.column <= lgsp_pkg::MaxSpans) rung_w[w.column] = w.weight;
          loads++;
        end
        lgsp_pkg::KIND_BOTTOM: begin
          if (w.column < lgsp_pkg::MaxSpans) bot_w[w.column] = w.weight;
          loads++;
        end
        default: begin
          owed.push_back(shortest(w));
          queries++;
        end
      endcase
    endfunction

    function void check_result(logic [lgsp_pkg::DistW-1:0] got);
      logic [lgsp_pkg::DistW-1:0] want;
      results++;
      if (owed.size() == 0) begin
        $error("distance word with nothing expected: %0d", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        $error("distance mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [lgsp_pkg::ColW-1:0] cfg_data_i = '0;

  lgsp_in_if  in_bus ();
  lgsp_out_if out_bus ();

  ladder_graph_shortest_path_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  dist_board board = new();
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned cur_span = 1;
  int unsigned phases = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.kind = lgsp_pkg::KIND_TOP;
    in_bus.column = '0;
    in_bus.weight = '0;
    in_bus.source_row = 1'b0;
    in_bus.source_col = '0;
    in_bus.target_row = 1'b0;
    in_bus.target_col = '0;
    out_bus.ready = 1'b0;
  end

  // result side: stall pattern switches between always ready, half and one-in-eight ready modes
  int unsigned stall_mode = 0, stall_cnt = 0;
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_cnt = $urandom_range(50, 300);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_bus.ready = 1'b1;
      1: out_bus.ready = ($urandom_range(0, 1) == 0);
      default: out_bus.ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) board.check_result(out_bus.distance);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send(word_t w);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_bus.valid = 1'b1;
    in_bus.kind = w.kind;
    in_bus.column = w.column;
    in_bus.weight = w.weight;
    in_bus.source_row = w.source_row;
    in_bus.source_col = w.source_col;
    in_bus.target_row = w.target_row;
    in_bus.target_col = w.target_col;
    forever begin
      @(posedge clk_i);
      if (in_bus.ready) break;
    end
    board.note_word(w);
  endtask

  // stop sending until every owed distance is back, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_span(int unsigned val);
    drain();
    cfg_we_i = 1'b1;
    cfg_data_i = lgsp_pkg::ColW'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.span_reg = lgsp_pkg::ColW'(val);
    cur_span = (val == 0) ? 1 : (val > lgsp_pkg::MaxSpans) ? lgsp_pkg::MaxSpans : val;
    phases++;
  endtask

  function automatic logic [lgsp_pkg::WeightW-1:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return '1;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic word_t load_word(lgsp_pkg::kind_e k, int unsigned col,
                                      logic [lgsp_pkg::WeightW-1:0] wt);
    word_t w;
    w.kind = k;
    w.column = lgsp_pkg::ColW'(col);
    w.weight = wt;
    w.source_row = 1'($urandom_range(0, 1));
    w.source_col = lgsp_pkg::ColW'($urandom_range(0, 2047));
    w.target_row = 1'($urandom_range(0, 1));
    w.target_col = lgsp_pkg::ColW'($urandom_range(0, 2047));
    return w;
  endfunction

  function automatic word_t query_word(int unsigned sr, int unsigned sc, int unsigned tr,
                                       int unsigned tc);
    word_t w;
    w.kind = lgsp_pkg::KIND_QUERY;
    w.column = lgsp_pkg::ColW'($urandom_range(0, 2047));
    w.weight = $urandom();
    w.source_row = sr[0];
    w.source_col = lgsp_pkg::ColW'(sc);
    w.target_row = tr[0];
    w.target_col = lgsp_pkg::ColW'(tc);
    return w;
  endfunction

  function automatic int unsigned rand_col(int unsigned t);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, t + 1);
  endfunction

  function automatic word_t random_word(int unsigned t);
    int unsigned pick, col;
    pick = $urandom_range(0, 9);
    if (pick < 2)
      return query_word($urandom_range(0, 1), rand_col(t), $urandom_range(0, 1), rand_col(t));
    col = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, MaxCol);
    case (pick % 3)
      0: return load_word(lgsp_pkg::KIND_TOP, col, rand_weight());
      1: return load_word(lgsp_pkg::KIND_RUNG, col, rand_weight());
      default: return load_word(lgsp_pkg::KIND_BOTTOM, col, rand_weight());
    endcase
  endfunction

  initial begin
    int unsigned spans [6] = '{0, 1, 3, 7, 20, MaxCol};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every entry a query can reach gets written before any query
    for (int c = 0; c <= MaxCol; c++) begin
      send(load_word(lgsp_pkg::KIND_TOP, c, rand_weight()));
      send(load_word(lgsp_pkg::KIND_RUNG, c, rand_weight()));
      send(load_word(lgsp_pkg::KIND_BOTTOM, c, rand_weight()));
    end

    // directed: reset span count, extremes, same node, saturated columns
    send(query_word(0, 0, 1, 1));
    send(query_word(1, 1, 1, 1));
    send(query_word(0, 2047, 1, 0));
    send(load_word(lgsp_pkg::KIND_TOP, 0, '1));
    send(load_word(lgsp_pkg::KIND_BOTTOM, 0, 32'h0));
    send(load_word(lgsp_pkg::KIND_RUNG, 1, '1));
    send(load_word(lgsp_pkg::KIND_TOP, lgsp_pkg::MaxSpans, 32'h5));  // out of range, dropped
    send(load_word(lgsp_pkg::KIND_BOTTOM, 2047, 32'h7));             // out of range, dropped
    send(load_word(lgsp_pkg::KIND_RUNG, lgsp_pkg::MaxSpans, 32'h9));
    send(load_word(lgsp_pkg::KIND_RUNG, 2047, 32'h3));               // out of range, dropped
    send(query_word(0, 0, 1, 2047));
    send(query_word(1, 0, 0, 1));
    set_span(2047);                                 // saturates to the max span count
    send(load_word(lgsp_pkg::KIND_TOP, 1023, '1));
    send(load_word(lgsp_pkg::KIND_BOTTOM, 1023, 32'h0));
    set_span(lgsp_pkg::MaxSpans);
    send(load_word(lgsp_pkg::KIND_RUNG, 1024, 32'h1));
    set_span(5);
    send(query_word(0, 0, 1, 5));
    send(query_word(1, 5, 0, 0));
    send(query_word(0, 3, 0, 2047));

    // random phases over several span counts
    foreach (spans[i]) begin
      set_span(spans[i]);
      for (int n = 0; n < 65; n++) begin
        send(random_word(cur_span));
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d loads and %0d queries over %0d span settings",
             board.loads, board.queries, phases);
    $display("%0d distances checked, %0d mismatches", board.results, board.errors);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lgsp_pkg.sv
hw/rtl/lgsp_if.sv
hw/rtl/ladder_graph_shortest_path_top.sv
hw/rtl/lgsp_checker.sv
tb/tb.sv
